// ----- sv/utf8_token_text_checker_macros.svh -----
// Assertion macros used by the checker module.
`ifndef UTF8_TOKEN_TEXT_CHECKER_MACROS_SVH
`define UTF8_TOKEN_TEXT_CHECKER_MACROS_SVH

`ifndef SYNTHESIS
`define UTC_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("utf8 checker assertion failed");
`define UTC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("utf8 checker assertion failed");
`else
`define UTC_ASSERT(label, clk, rstn, prop)
`define UTC_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ----- sv/utf8_tc_pkg.sv -----
package utf8_tc_pkg;

    localparam int ByteW = 8;

    typedef enum logic [2:0] {
        RULE_NONE = 3'd0,
        RULE_E0   = 3'd1,
        RULE_ED   = 3'd2,
        RULE_F0   = 3'd3,
        RULE_F4   = 3'd4,
        RULE_C2   = 3'd5
    } rule_t;

    typedef struct packed {
        logic        failed;
        logic [1:0]  pending;
        rule_t       rule;
    } tok_state_t;

    localparam tok_state_t StateReset = '{failed: 1'b0, pending: 2'd0, rule: RULE_NONE};

endpackage

// ----- sv/utf8_tc_step.sv -----
module utf8_tc_step (
    input  utf8_tc_pkg::tok_state_t        cur_state,
    input  logic [utf8_tc_pkg::ByteW-1:0]  byte_in,
    input  logic                           last_in,
    output utf8_tc_pkg::tok_state_t        next_state,
    output logic                           verdict
);

    utf8_tc_pkg::tok_state_t upd;
    logic                    cont_ok;

    always_comb begin
        case (cur_state.rule)
            utf8_tc_pkg::RULE_E0: cont_ok = (byte_in >= 8'ha0) && (byte_in <= 8'hbf);
            utf8_tc_pkg::RULE_ED: cont_ok = (byte_in >= 8'h80) && (byte_in <= 8'h9f);
            utf8_tc_pkg::RULE_F0: cont_ok = (byte_in >= 8'h90) && (byte_in <= 8'hbf);
            utf8_tc_pkg::RULE_F4: cont_ok = (byte_in >= 8'h80) && (byte_in <= 8'h8f);
            utf8_tc_pkg::RULE_C2: cont_ok = (byte_in >= 8'ha0) && (byte_in <= 8'hbf);
            default:              cont_ok = (byte_in >= 8'h80) && (byte_in <= 8'hbf);
        endcase
    end

    always_comb begin
        upd = cur_state;
        if (!cur_state.failed) begin
            if (cur_state.pending != 2'd0) begin
                if (cont_ok) begin
                    upd.pending = cur_state.pending - 2'd1;
                    upd.rule    = utf8_tc_pkg::RULE_NONE;
                end else begin
                    upd = '{failed: 1'b1, pending: 2'd0, rule: utf8_tc_pkg::RULE_NONE};
                end
            end else if (byte_in <= 8'h7f) begin
                if ((byte_in < 8'h20) || (byte_in == 8'h7f)) begin
                    upd = '{failed: 1'b1, pending: 2'd0, rule: utf8_tc_pkg::RULE_NONE};
                end
            end else if ((byte_in >= 8'hc2) && (byte_in <= 8'hdf)) begin
                upd.pending = 2'd1;
                upd.rule    = (byte_in == 8'hc2) ? utf8_tc_pkg::RULE_C2
                                                 : utf8_tc_pkg::RULE_NONE;
            end else if ((byte_in >= 8'he0) && (byte_in <= 8'hef)) begin
                upd.pending = 2'd2;
                upd.rule    = (byte_in == 8'he0) ? utf8_tc_pkg::RULE_E0 :
                              (byte_in == 8'hed) ? utf8_tc_pkg::RULE_ED :
                                                   utf8_tc_pkg::RULE_NONE;
            end else if ((byte_in >= 8'hf0) && (byte_in <= 8'hf4)) begin
                upd.pending = 2'd3;
                upd.rule    = (byte_in == 8'hf0) ? utf8_tc_pkg::RULE_F0 :
                              (byte_in == 8'hf4) ? utf8_tc_pkg::RULE_F4 :
                                                   utf8_tc_pkg::RULE_NONE;
            end else begin
                upd = '{failed: 1'b1, pending: 2'd0, rule: utf8_tc_pkg::RULE_NONE};
            end
        end
        verdict    = !upd.failed && (upd.pending == 2'd0);
        next_state = last_in ? utf8_tc_pkg::StateReset : upd;
    end

endmodule

// ----- sv/utf8_token_text_checker.sv -----
// Strict UTF-8 checker for token text.
// The input stream carries one byte of a token per transfer in s_tdata, with
// s_tlast high on the final byte of the token. The result stream carries one
// verdict per token in m_tdata bit 0: 1 when the whole token was strict,
// printable UTF-8, 0 otherwise. Bytes that are not the last of a token give
// no result transfer.
// Each accepted byte is held in an input register and then checked against
// the token state; the verdict of a last byte is registered in the output
// register, which drives m_tvalid. One byte is taken every cycle unless a
// last byte waits in the input register behind an unread verdict.
// When the receiver stalls, a waiting verdict stays in the output register;
// bytes that are not last still pass and update the token state, and a
// second last byte waits in the input register until the verdict is taken,
// which then holds s_tready low.
// A synchronous active-low reset empties both registers and clears the
// token state, so the next byte starts a new token.
`include "utf8_token_text_checker_macros.svh"

module utf8_token_text_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // byte_value[7:0]
    input  logic       s_tlast,   // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // token_valid[0], zero fill [7:1]
);

    logic                              in_valid_reg;
    logic [utf8_tc_pkg::ByteW-1:0]     in_byte_reg;
    logic                              in_last_reg;
    logic                              m_valid_reg;
    logic                              m_valid_next;
    logic                              m_data_reg;
    utf8_tc_pkg::tok_state_t           state_reg;
    utf8_tc_pkg::tok_state_t           state_next;
    logic                              verdict;
    logic                              advance;

    utf8_tc_step u_step (
        .cur_state  (state_reg),
        .byte_in    (in_byte_reg),
        .last_in    (in_last_reg),
        .next_state (state_next),
        .verdict    (verdict)
    );

    assign advance  = in_valid_reg && (!in_last_reg || !m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        if (advance && in_last_reg) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            state_reg    <= utf8_tc_pkg::StateReset;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            m_valid_reg <= m_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && in_last_reg) begin
            m_data_reg <= verdict;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_data_reg};

    `UTC_ASSERT(a_last_gives_result, aclk, aresetn, (advance && in_last_reg) |=> m_tvalid)
    `UTC_ASSERT(a_failed_clears, aclk, aresetn,
        state_reg.failed |->
            (state_reg.pending == 2'd0 && state_reg.rule == utf8_tc_pkg::RULE_NONE))
    `UTC_ASSERT(a_rule_needs_pending, aclk, aresetn,
        (state_reg.rule != utf8_tc_pkg::RULE_NONE) |-> (state_reg.pending != 2'd0))
    `UTC_ASSERT(a_token_end_resets, aclk, aresetn,
        (advance && in_last_reg) |=> (state_reg == utf8_tc_pkg::StateReset))
    `UTC_ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> (!m_tvalid && !in_valid_reg))

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    logic       aclk;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;

    bit         steady = 1'b0;
    logic [7:0] tok_bytes[$];

    localparam logic [8:0] DirectedBytes[27] = '{
        9'h141,
        9'h07E, 9'h120,
        9'h100,
        9'h17F,
        9'h0C2, 9'h180,
        9'h0DF, 9'h1BF,
        9'h0E0, 9'h0A0, 9'h180,
        9'h0ED, 9'h0A0, 9'h180,
        9'h0F0, 9'h18F,
        9'h0F4, 9'h190,
        9'h0F4, 9'h08F, 9'h0BF, 9'h1BF,
        9'h1E1,
        9'h1FF,
        9'h1C0,
        9'h180
    };

    class verdict_board;
        logic                 tok_bad;
        logic [1:0]           cont_left;
        utf8_tc_pkg::rule_t   next_rule;
        bit                   verdicts[$];
        int                   mismatches;
        int                   taken;

        function new();
            clear_token();
            mismatches = 0;
            taken = 0;
        endfunction

        function void clear_token();
            tok_bad = 1'b0;
            cont_left = 2'd0;
            next_rule = utf8_tc_pkg::RULE_NONE;
        endfunction

        function void mark_bad();
            tok_bad = 1'b1;
            cont_left = 2'd0;
            next_rule = utf8_tc_pkg::RULE_NONE;
        endfunction

        function bit cont_in_range(logic [7:0] b, utf8_tc_pkg::rule_t r);
            case (r)
                utf8_tc_pkg::RULE_E0, utf8_tc_pkg::RULE_C2: return b >= 8'hA0 && b <= 8'hBF;
                utf8_tc_pkg::RULE_ED: return b >= 8'h80 && b <= 8'h9F;
                utf8_tc_pkg::RULE_F0: return b >= 8'h90 && b <= 8'hBF;
                utf8_tc_pkg::RULE_F4: return b >= 8'h80 && b <= 8'h8F;
                default: return b >= 8'h80 && b <= 8'hBF;
            endcase
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            if (!tok_bad) begin
                if (cont_left != 2'd0) begin
                    if (cont_in_range(b, next_rule)) begin
                        cont_left = cont_left - 2'd1;
                        next_rule = utf8_tc_pkg::RULE_NONE;
                    end else begin
                        mark_bad();
                    end
                end else if (b <= 8'h7F) begin
                    if (b < 8'h20 || b == 8'h7F) begin
                        mark_bad();
                    end
                end else if (b >= 8'hC2 && b <= 8'hDF) begin
                    cont_left = 2'd1;
                    next_rule = (b == 8'hC2) ? utf8_tc_pkg::RULE_C2 : utf8_tc_pkg::RULE_NONE;
                end else if (b >= 8'hE0 && b <= 8'hEF) begin
                    cont_left = 2'd2;
                    next_rule = (b == 8'hE0) ? utf8_tc_pkg::RULE_E0 :
                                (b == 8'hED) ? utf8_tc_pkg::RULE_ED : utf8_tc_pkg::RULE_NONE;
                end else if (b >= 8'hF0 && b <= 8'hF4) begin
                    cont_left = 2'd3;
                    next_rule = (b == 8'hF0) ? utf8_tc_pkg::RULE_F0 :
                                (b == 8'hF4) ? utf8_tc_pkg::RULE_F4 : utf8_tc_pkg::RULE_NONE;
                end else begin
                    mark_bad();
                end
            end
            if (last) begin
                verdicts.push_back(!tok_bad && cont_left == 2'd0);
                clear_token();
            end
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_verdict(logic [7:0] data);
            bit want;
            taken++;
            if (verdicts.size() == 0) begin
                report($sformatf("verdict transfer %02h with none expected", data));
                return;
            end
            want = verdicts.pop_front();
            if (data[0] !== want) begin
                report($sformatf("token_valid %b, expected %b", data[0], want));
            end
            if (data[7:1] !== 7'd0) begin
                report($sformatf("fill bits of m_tdata not zero: %02h", data));
            end
        endtask
    endclass

    verdict_board board = new();

    utf8_token_text_checker dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    task send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        board.note_byte(b, last);
    endtask

    function automatic void build_token();
        int         chars;
        int         pos;
        logic [7:0] lead;
        tok_bytes.delete();
        if ($urandom_range(0, 15) == 0) begin
            chars = $urandom_range(1, 6);
            repeat (chars) tok_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        chars = $urandom_range(1, 5);
        repeat (chars) begin
            case ($urandom_range(0, 3))
                0: begin
                    tok_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
                end
                1: begin
                    lead = ($urandom_range(0, 2) == 0) ? 8'hC2
                                                       : 8'($urandom_range(8'hC2, 8'hDF));
                    tok_bytes.push_back(lead);
                    tok_bytes.push_back(
                        8'($urandom_range((lead == 8'hC2) ? 8'hA0 : 8'h80, 8'hBF)));
                end
                2: begin
                    case ($urandom_range(0, 3))
                        0: lead = 8'hE0;
                        1: lead = 8'hED;
                        default: lead = 8'($urandom_range(8'hE0, 8'hEF));
                    endcase
                    tok_bytes.push_back(lead);
                    if (lead == 8'hE0) begin
                        tok_bytes.push_back(8'($urandom_range(8'hA0, 8'hBF)));
                    end else if (lead == 8'hED) begin
                        tok_bytes.push_back(8'($urandom_range(8'h80, 8'h9F)));
                    end else begin
                        tok_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
                    end
                    tok_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0: lead = 8'hF0;
                        1: lead = 8'hF4;
                        default: lead = 8'($urandom_range(8'hF0, 8'hF4));
                    endcase
                    tok_bytes.push_back(lead);
                    if (lead == 8'hF0) begin
                        tok_bytes.push_back(8'($urandom_range(8'h90, 8'hBF)));
                    end else if (lead == 8'hF4) begin
                        tok_bytes.push_back(8'($urandom_range(8'h80, 8'h8F)));
                    end else begin
                        tok_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
                    end
                    tok_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
                    tok_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
                end
            endcase
        end
        if ($urandom_range(0, 7) == 0) begin
            pos = $urandom_range(0, tok_bytes.size() - 1);
            tok_bytes[pos] = 8'($urandom_range(0, 255));
        end else if ($urandom_range(0, 7) == 0 && tok_bytes.size() > 1) begin
            void'(tok_bytes.pop_back());
        end
    endfunction

    initial begin
        int sent;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (DirectedBytes[i]) begin
            send_byte(DirectedBytes[i][7:0], DirectedBytes[i][8]);
        end
        sent = 0;
        while (sent < 1200) begin
            if ($urandom_range(0, 7) == 0) begin
                steady = !steady;
            end
            build_token();
            foreach (tok_bytes[i]) begin
                send_byte(tok_bytes[i], i == tok_bytes.size() - 1);
            end
            sent += tok_bytes.size();
        end
        s_tvalid <= 1'b0;
        while (board.verdicts.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (board.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // The receiver holds off twice for a long stretch so the block backs up and stalls its input.
    initial begin
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (board.taken == 30 || board.taken == 150) begin
                stall = 250;
            end else begin
                stall = steady ? 0 : $urandom_range(0, 3);
            end
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            board.check_verdict(m_tdata);
        end
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
